// ----- design/hrt_pkg.sv -----
`default_nettype none
package hrt_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned CODE_W = 10;
  localparam logic [CODE_W-1:0] CODE_MAX = 10'd999;

  localparam logic [2:0] PH_VERSION = 3'd0;
  localparam logic [2:0] PH_CODE    = 3'd1;
  localparam logic [2:0] PH_TEXT    = 3'd2;
  localparam logic [2:0] PH_HNAME   = 3'd3;
  localparam logic [2:0] PH_HSPACE  = 3'd4;
  localparam logic [2:0] PH_HVALUE  = 3'd5;
  localparam logic [2:0] PH_SEP     = 3'd6;
  localparam logic [2:0] PH_BODY    = 3'd7;

  localparam logic [2:0] K_DROP    = 3'd0;
  localparam logic [2:0] K_VERSION = 3'd1;
  localparam logic [2:0] K_CODE    = 3'd2;
  localparam logic [2:0] K_TEXT    = 3'd3;
  localparam logic [2:0] K_HNAME   = 3'd4;
  localparam logic [2:0] K_HVALUE  = 3'd5;
  localparam logic [2:0] K_BODY    = 3'd6;

  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_VERSION = 3'd1;
  localparam logic [2:0] E_CODE    = 3'd2;
  localparam logic [2:0] E_TEXT    = 3'd3;
  localparam logic [2:0] E_HNAME   = 3'd4;
  localparam logic [2:0] E_HVALUE  = 3'd5;

  localparam int unsigned OUT_DATA_W = 32;

  typedef struct packed {
    logic [2:0]        phase;
    logic [CODE_W-1:0] code;
    logic              seen;
    logic              stopped;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]        byte_kind;
    logic [7:0]        byte_out;
    logic              field_end;
    logic [2:0]        ended_kind;
    logic [CODE_W-1:0] status_code;
    logic              code_error;
    logic [2:0]        phase;
  } token_t;

endpackage
`default_nettype wire

// ----- design/http_response_tokenizer_top.sv -----
`default_nettype none
// HTTP/1.1 response tokenizer. One response byte per input word, one tagged word out
// per byte, in order. Throughput is one byte per clock while the output is taken; the
// path is an input register, then a result register, with the parse state updated as
// a byte moves into the result register. in_tready drops only while the result register
// is full and out_tready is low. The parser moves from the version phase to the body,
// cycling through the header phases, and returns to version only through reset.
module http_response_tokenizer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [hrt_pkg::OUT_DATA_W-1:0] out_tdata,
                                       // [7:0] byte_out, [8] field_end, [11:9] ended_kind,
                                       // [21:12] status_code, [22] code_error,
                                       // [25:23] phase, [31:26] zero
  output logic [2:0]       out_tuser   // [2:0] byte_kind
);

  logic                  in_vld_r;
  logic [7:0]            in_byte_r;
  logic                  out_vld_r;
  hrt_pkg::token_t       tok_r;
  hrt_pkg::token_t       tok_nxt;
  hrt_pkg::parse_state_t st_r;
  hrt_pkg::parse_state_t st_nxt;
  logic                  out_free;
  logic                  advance;

  assign out_free  = !out_vld_r || out_tready;
  assign advance   = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  hrt_step u_step (
    .data_byte (in_byte_r),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .tok       (tok_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      st_r       <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (out_free) begin
        out_vld_r <= in_vld_r;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (advance) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = tok_r.byte_kind;
  assign out_tdata  = {6'd0, tok_r.phase, tok_r.code_error, tok_r.status_code,
                       tok_r.ended_kind, tok_r.field_end, tok_r.byte_out};

endmodule
`default_nettype wire

// ----- design/hrt_step.sv -----
`default_nettype none
module hrt_step (
  input  wire logic [7:0]          data_byte,
  input  wire hrt_pkg::parse_state_t st,
  output hrt_pkg::parse_state_t    st_nxt,
  output hrt_pkg::token_t          tok
);

  logic [2:0]  kind;
  logic [2:0]  ended;
  logic [2:0]  ph;
  logic        is_digit;
  logic [13:0] acc_mul;
  logic [13:0] acc_sum;

  assign is_digit = (data_byte >= hrt_pkg::CH_ZERO) && (data_byte <= hrt_pkg::CH_NINE);
  assign acc_mul  = {1'b0, st.code, 3'b000} + {3'b000, st.code, 1'b0};
  assign acc_sum  = acc_mul + {10'd0, data_byte[3:0]};

  always_comb begin
    kind   = hrt_pkg::K_DROP;
    ended  = hrt_pkg::E_NONE;
    ph     = st.phase;
    st_nxt = st;
    unique case (st.phase)
      hrt_pkg::PH_VERSION: begin
        if (data_byte == hrt_pkg::CH_SPACE) begin
          ended = hrt_pkg::E_VERSION;
          ph    = hrt_pkg::PH_CODE;
        end else begin
          kind = hrt_pkg::K_VERSION;
        end
      end
      hrt_pkg::PH_CODE: begin
        if (data_byte == hrt_pkg::CH_SPACE) begin
          ended = hrt_pkg::E_CODE;
          ph    = hrt_pkg::PH_TEXT;
        end else begin
          kind = hrt_pkg::K_CODE;
          if (is_digit) begin
            if (!st.stopped) begin
              st_nxt.code = (acc_sum > {4'd0, hrt_pkg::CODE_MAX}) ?
                            hrt_pkg::CODE_MAX : acc_sum[hrt_pkg::CODE_W-1:0];
              st_nxt.seen = 1'b1;
            end
          end else begin
            st_nxt.stopped = 1'b1;
          end
        end
      end
      hrt_pkg::PH_TEXT: begin
        if (data_byte == hrt_pkg::CH_LF) begin
          ended = hrt_pkg::E_TEXT;
          ph    = hrt_pkg::PH_HNAME;
        end else if (data_byte != hrt_pkg::CH_CR) begin
          kind = hrt_pkg::K_TEXT;
        end
      end
      hrt_pkg::PH_HNAME: begin
        if (data_byte == hrt_pkg::CH_CR) begin
          ph = hrt_pkg::PH_SEP;
        end else if (data_byte == hrt_pkg::CH_COLON) begin
          ended = hrt_pkg::E_HNAME;
          ph    = hrt_pkg::PH_HSPACE;
        end else begin
          kind = hrt_pkg::K_HNAME;
        end
      end
      hrt_pkg::PH_HSPACE: begin
        if (data_byte == hrt_pkg::CH_SPACE) begin
          ph = hrt_pkg::PH_HVALUE;
        end
      end
      hrt_pkg::PH_HVALUE: begin
        if (data_byte == hrt_pkg::CH_LF) begin
          ended = hrt_pkg::E_HVALUE;
          ph    = hrt_pkg::PH_HNAME;
        end else if (data_byte != hrt_pkg::CH_CR) begin
          kind = hrt_pkg::K_HVALUE;
        end
      end
      hrt_pkg::PH_SEP: begin
        if (data_byte == hrt_pkg::CH_LF) begin
          ph = hrt_pkg::PH_BODY;
        end
      end
      default: begin
        kind = hrt_pkg::K_BODY;
      end
    endcase
    st_nxt.phase = ph;
  end

  assign tok.byte_kind   = kind;
  assign tok.byte_out    = data_byte;
  assign tok.field_end   = (ended != hrt_pkg::E_NONE);
  assign tok.ended_kind  = ended;
  assign tok.status_code = st_nxt.code;
  assign tok.code_error  = (ph >= hrt_pkg::PH_TEXT) && !st_nxt.seen;
  assign tok.phase       = ph;

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import hrt_pkg::*;

  class token_scoreboard;
    logic [2:0]        phase;
    logic [CODE_W-1:0] code;
    logic              seen;
    logic              stopped;
    token_t            expected_tokens[$];
    int unsigned       failures;

    function new();
      phase    = PH_VERSION;
      code     = '0;
      seen     = 1'b0;
      stopped  = 1'b0;
      failures = 0;
    endfunction

    function int unsigned pending_count();
      return expected_tokens.size();
    endfunction

    function void note_byte(logic [7:0] c);
      token_t      t;
      int unsigned v;
      t = '0;
      t.byte_out   = c;
      t.byte_kind  = K_DROP;
      t.ended_kind = E_NONE;
      case (phase)
        PH_VERSION: begin
          if (c == CH_SPACE) begin
            t.ended_kind = E_VERSION;
            phase = PH_CODE;
          end else t.byte_kind = K_VERSION;
        end
        PH_CODE: begin
          if (c == CH_SPACE) begin
            t.ended_kind = E_CODE;
            phase = PH_TEXT;
          end else begin
            t.byte_kind = K_CODE;
            if (c >= CH_ZERO && c <= CH_NINE) begin
              if (!stopped) begin
                v = code * 10 + (c - CH_ZERO);
                code = (v > CODE_MAX) ? CODE_MAX : 10'(v);
                seen = 1'b1;
              end
            end else stopped = 1'b1;
          end
        end
        PH_TEXT: begin
          if (c == CH_LF) begin
            t.ended_kind = E_TEXT;
            phase = PH_HNAME;
          end else if (c != CH_CR) t.byte_kind = K_TEXT;
        end
        PH_HNAME: begin
          if (c == CH_CR) phase = PH_SEP;
          else if (c == CH_COLON) begin
            t.ended_kind = E_HNAME;
            phase = PH_HSPACE;
          end else t.byte_kind = K_HNAME;
        end
        PH_HSPACE: begin
          if (c == CH_SPACE) phase = PH_HVALUE;
        end
        PH_HVALUE: begin
          if (c == CH_LF) begin
            t.ended_kind = E_HVALUE;
            phase = PH_HNAME;
          end else if (c != CH_CR) t.byte_kind = K_HVALUE;
        end
        PH_SEP: begin
          if (c == CH_LF) phase = PH_BODY;
        end
        default: t.byte_kind = K_BODY;
      endcase
      t.field_end   = (t.ended_kind != E_NONE);
      t.status_code = code;
      t.code_error  = (phase >= PH_TEXT) && !seen;
      t.phase       = phase;
      expected_tokens = {expected_tokens, t};
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_word(logic [31:0] data, logic [2:0] user);
      token_t t;
      if (expected_tokens.size() == 0) begin
        $error("output word with no byte pending: data %h user %0d", data, user);
        failures++;
        return;
      end
      t = expected_tokens.pop_front();
      compare("byte_kind", t.byte_kind, user);
      compare("byte_out", t.byte_out, data[7:0]);
      compare("field_end", t.field_end, data[8]);
      compare("ended_kind", t.ended_kind, data[11:9]);
      compare("status_code", t.status_code, data[21:12]);
      compare("code_error", t.code_error, data[22]);
      compare("phase", t.phase, data[25:23]);
      compare("pad", 0, data[31:26]);
    endfunction
  endclass

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES = 80;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  token_scoreboard board;
  int unsigned     stall_cycles = 0;
  int unsigned     bytes_sent   = 0;
  int unsigned     rx_count     = 0;
  bit              tx_steady    = 1'b0;
  bit              rx_steady    = 1'b0;
  bit              held_off     = 1'b0;

  http_response_tokenizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] pick_byte(input logic [7:0] ex0, input logic [7:0] ex1);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ex0 || b == ex1);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (bytes_sent % 64 == 0) tx_steady = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_str(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic send_rand(input int unsigned n, input logic [7:0] ex0, input logic [7:0] ex1);
    repeat (n) send_byte(pick_byte(ex0, ex1));
  endtask

  task automatic send_header();
    int unsigned n;
    n = $urandom_range(0, 6);
    send_rand(n, CH_CR, CH_COLON);
    send_byte(CH_COLON);
    // junk before the space is swallowed
    if ($urandom_range(0, 3) == 0) send_rand($urandom_range(1, 3), CH_SPACE, CH_SPACE);
    send_byte(CH_SPACE);
    n = $urandom_range(0, 10);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) send_byte(CH_CR);
      else send_byte(pick_byte(CH_LF, CH_CR));
    end
    send_byte(CH_LF);
  endtask

  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (rst_n && in_tvalid && in_tready) board.note_byte(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_word(out_tdata, out_tuser);
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned gap;
    wait (rst_n === 1'b1);
    forever begin
      // long hold-off so the pipeline fills and backs up the input
      if (rx_count == 250 && !held_off) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = rx_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      rx_count++;
      if (rx_count % 64 == 0) rx_steady = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_str("H");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_str("TP/1");
    send_byte(CH_SPACE);
    case ($urandom_range(0, 3))
      0: send_str("9999x9");                   // saturates, then stops
      1: send_str("x12");                      // no leading digit
      2: ;                                     // empty code
      default: begin
        repeat ($urandom_range(1, 4))
          send_byte(8'(pick_byte(CH_SPACE, CH_SPACE) % 10 + CH_ZERO));
      end
    endcase
    send_byte(CH_SPACE);
    send_str("O\rK");
    send_rand($urandom_range(0, 4), CH_LF, CH_LF);
    send_byte(CH_LF);
    send_str("N:x v\r\n");
    send_str(": \n");

    while (bytes_sent < 600) send_header();

    // blank line, possibly after an abandoned partial name
    send_rand($urandom_range(0, 3), CH_CR, CH_COLON);
    send_byte(CH_CR);
    send_rand($urandom_range(0, 3), CH_LF, CH_LF);
    send_byte(CH_LF);
    repeat (200) send_byte(8'($urandom_range(0, 255)));
    send_byte(8'h00);
    send_byte(8'hFF);
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (board.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.failures == 0 && board.pending_count() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
